// ===== design/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg: shared types and constants for the go-back-N window controller
// Holds the beat payload structs, command and phase codes, configuration
// register indexes and reset values.
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int SEQ_BITS_DEF = 8;

    localparam logic [15:0] ONE_PKT   = 16'h0100;
    localparam logic [2:0]  DUP_LIMIT = 3'd3;
    localparam logic [2:0]  DUP_MAX   = 3'd7;

    localparam logic [7:0]  RWND_RST   = 8'd10;
    localparam logic [31:0] TIMEOUT_RST = 32'd1000;
    localparam logic [7:0]  THRESH_RST = 8'd8;

    // 2^16 / cwnd needs 17 quotient bits
    localparam int DIV_STEPS = 17;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [1:0] CFG_RWND    = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_THRESH  = 2'd2;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_ACK   = 2'd1,
        CMD_SEND  = 2'd2,
        CMD_START = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        PH_SLOW  = 2'd0,
        PH_AVOID = 2'd1,
        PH_RECOV = 2'd2
    } t_phase;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] ack_seq;
        logic       ack_good;
    } t_in_beat;

    typedef struct packed {
        logic       send_granted;
        logic [7:0] send_seq;
        logic [7:0] window_now;
        logic       went_back;
        logic       timed_out;
        logic [1:0] phase;
        logic [7:0] cwnd_whole;
        logic [7:0] threshold_now;
    } t_out_beat;

endpackage

// ===== design/gbn_window_reno_congestion.sv =====
// ----------------------------------------------------------------------------
// gbn_window_reno_congestion: go-back-N sender window with Reno control
// One command beat in, one status beat out. Tracks base/next sequence,
// Q8.8 congestion window, slow start threshold, duplicate ACKs and timeout.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one command per
//   beat: tick, ACK, send request or session start. Output channel
//   (o_out_valid / i_out_stall / o_out_data) returns exactly one status beat
//   per command, showing the state after that command.
//   Configuration writes (i_cfg_valid / o_cfg_ready) load receiver window,
//   timeout ticks and initial threshold; issue them only while idle.
//   Most commands pass from accept through the execute and response steps to
//   the output register. A new ACK in congestion avoidance runs the restoring
//   divider for 2^16 / cwnd between those steps, one quotient bit per cycle.
//   A new command waits until the previous one has left its response step.
//   o_in_stall is high while a command is in work; the next command can be
//   taken while a finished beat still waits in the output register.
//   A stalled receiver holds the output beat; a command finishing behind it
//   waits in its response step until the register frees.
//   Reset loads window 1.0, threshold 8, sequence numbers 0, slow start,
//   and the configuration reset values.
// ----------------------------------------------------------------------------
module gbn_window_reno_congestion #(
    parameter int SEQ_BITS = gbn_pkg::SEQ_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  gbn_pkg::t_in_beat     i_in_data,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output gbn_pkg::t_out_beat    o_out_data,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data
);

    localparam int SW = (SEQ_BITS > 8) ? SEQ_BITS : 8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_RESP
    } t_state;

    t_state                        r_state;

    // configuration
    logic [7:0]                    r_rwnd;
    logic [31:0]                   r_timeout;
    logic [7:0]                    r_init_thresh;

    // protocol state
    logic [SEQ_BITS-1:0]           r_next;
    logic [SEQ_BITS-1:0]           r_base;
    logic [15:0]                   r_cwnd;
    logic [7:0]                    r_thresh;
    logic [SEQ_BITS-1:0]           r_last_ack;
    logic [2:0]                    r_dup;
    logic [1:0]                    r_phase;
    logic                          r_resend;
    logic [31:0]                   r_ticks;

    // captured command and per-command flags
    gbn_pkg::t_in_beat             r_cmd;
    logic                          r_granted;
    logic [SEQ_BITS-1:0]           r_sseq;
    logic                          r_back;
    logic                          r_tout;

    // divider
    logic [15:0]                   r_div_d;
    logic [15:0]                   r_rem;
    logic [16:0]                   r_quo;
    logic [gbn_pkg::DIV_CNT_W-1:0] r_div_cnt;

    // output register
    logic                          r_out_valid;
    gbn_pkg::t_out_beat            r_out;

    // ------------------------------------------------------------------
    // combinational helpers
    // ------------------------------------------------------------------
    logic [SW-1:0]        ack_ext;
    logic [SEQ_BITS-1:0]  ack_seq;
    logic                 ack_repeat;
    logic [2:0]           dup_inc;
    logic [16:0]          cw_sum1;
    logic [15:0]          cw_plus1;
    logic [7:0]           cw_whole;
    logic [7:0]           win;
    logic [7:0]           half_cw;
    logic [7:0]           half_plus3;
    logic [15:0]          slow_cw;
    logic [2:0]           slow_dup;
    logic [SEQ_BITS-1:0]  send_from;
    logic [SEQ_BITS-1:0]  send_diff;
    logic                 send_ok;
    logic [31:0]          ticks_inc;
    logic [16:0]          rem_sh;
    logic                 rem_ge;
    logic [16:0]          rem_sub;
    logic [16:0]          quo_next;
    logic [17:0]          div_sum;
    logic [15:0]          div_cw;
    logic [SW-1:0]        sseq_ext;
    logic                 out_free;

    assign ack_ext    = SW'(r_cmd.ack_seq);
    assign ack_seq    = ack_ext[SEQ_BITS-1:0];
    assign ack_repeat = (ack_seq == r_last_ack);
    assign dup_inc    = (r_dup < gbn_pkg::DUP_MAX) ? r_dup + 3'd1 : r_dup;

    assign cw_sum1    = {1'b0, r_cwnd} + {1'b0, gbn_pkg::ONE_PKT};
    assign cw_plus1   = cw_sum1[16] ? 16'hFFFF : cw_sum1[15:0];
    assign cw_whole   = r_cwnd[15:8];
    assign win        = (r_rwnd < cw_whole) ? r_rwnd : cw_whole;
    assign half_cw    = {1'b0, r_cwnd[15:9]};

    // slow start ACK before the third-duplicate check
    assign slow_cw    = ack_repeat ? r_cwnd : cw_plus1;
    assign slow_dup   = ack_repeat ? dup_inc : 3'd0;
    assign half_plus3 = {1'b0, slow_cw[15:9]} + 8'd3;

    assign send_from  = r_resend ? r_base : r_next;
    assign send_diff  = send_from - r_base;
    assign send_ok    = SW'(send_diff) < SW'(win);

    assign ticks_inc  = (r_ticks != 32'hFFFF_FFFF) ? r_ticks + 32'd1 : r_ticks;

    assign rem_sh     = {r_rem, r_quo[16]};
    assign rem_ge     = rem_sh >= {1'b0, r_div_d};
    assign rem_sub    = rem_sh - {1'b0, r_div_d};
    assign quo_next   = {r_quo[15:0], rem_ge};
    assign div_sum    = {2'b00, r_cwnd} + {1'b0, quo_next};
    assign div_cw     = (div_sum > 18'h0FFFF) ? 16'hFFFF : div_sum[15:0];

    assign sseq_ext   = SW'(r_sseq);
    assign out_free   = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // sequencer, state and output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_rwnd        <= gbn_pkg::RWND_RST;
            r_timeout     <= gbn_pkg::TIMEOUT_RST;
            r_init_thresh <= gbn_pkg::THRESH_RST;
            r_next        <= '0;
            r_base        <= '0;
            r_cwnd        <= gbn_pkg::ONE_PKT;
            r_thresh      <= gbn_pkg::THRESH_RST;
            r_last_ack    <= '0;
            r_dup         <= '0;
            r_phase       <= gbn_pkg::PH_SLOW;
            r_resend      <= 1'b0;
            r_ticks       <= '0;
            r_out_valid   <= 1'b0;
            r_div_cnt     <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    gbn_pkg::CFG_RWND:    r_rwnd        <= i_cfg_data[7:0];
                    gbn_pkg::CFG_TIMEOUT: r_timeout     <= i_cfg_data;
                    gbn_pkg::CFG_THRESH:  r_init_thresh <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= i_in_data;
                        r_state <= S_EXEC;
                    end
                end

                S_EXEC: begin
                    r_granted <= 1'b0;
                    r_sseq    <= '0;
                    r_back    <= 1'b0;
                    r_tout    <= 1'b0;
                    r_state   <= S_RESP;
                    case (gbn_pkg::t_cmd'(r_cmd.command))
                        gbn_pkg::CMD_TICK: begin
                            r_ticks <= ticks_inc;
                            if (ticks_inc > r_timeout) begin
                                r_tout   <= 1'b1;
                                r_resend <= 1'b1;
                                r_ticks  <= '0;
                                r_thresh <= half_cw;
                                r_cwnd   <= gbn_pkg::ONE_PKT;
                                r_dup    <= '0;
                                r_phase  <= gbn_pkg::PH_SLOW;
                            end
                        end

                        gbn_pkg::CMD_ACK: begin
                            if (r_cmd.ack_good) begin
                                r_base  <= ack_seq;
                                r_ticks <= '0;
                                case (r_phase)
                                    gbn_pkg::PH_SLOW: begin
                                        r_dup  <= slow_dup;
                                        r_cwnd <= slow_cw;
                                        if (!ack_repeat) begin
                                            r_last_ack <= ack_seq;
                                        end
                                        if (slow_cw >= {r_thresh, 8'h00}) begin
                                            r_phase <= gbn_pkg::PH_AVOID;
                                        end
                                        // third duplicate: halve and enter recovery
                                        if (slow_dup == gbn_pkg::DUP_LIMIT) begin
                                            r_resend <= 1'b1;
                                            r_thresh <= {1'b0, slow_cw[15:9]};
                                            r_cwnd   <= {half_plus3, 8'h00};
                                            r_phase  <= gbn_pkg::PH_RECOV;
                                        end
                                    end

                                    gbn_pkg::PH_AVOID: begin
                                        if (ack_repeat) begin
                                            r_dup <= dup_inc;
                                            if (dup_inc == gbn_pkg::DUP_LIMIT) begin
                                                r_resend <= 1'b1;
                                                r_thresh <= {1'b0, slow_cw[15:9]};
                                                r_cwnd   <= {half_plus3, 8'h00};
                                                r_phase  <= gbn_pkg::PH_RECOV;
                                            end
                                        end else begin
                                            // start 2^16 / cwnd on the divider
                                            r_dup      <= '0;
                                            r_last_ack <= ack_seq;
                                            r_div_d    <= (r_cwnd == 16'h0000) ? 16'h0001
                                                                               : r_cwnd;
                                            r_rem      <= '0;
                                            r_quo      <= 17'h10000;
                                            r_div_cnt  <= gbn_pkg::DIV_CNT_W'(
                                                              gbn_pkg::DIV_STEPS - 1);
                                            r_state    <= S_DIV;
                                        end
                                    end

                                    default: begin
                                        if (ack_repeat) begin
                                            r_cwnd <= cw_plus1;
                                        end else if (ack_seq == r_next) begin
                                            r_phase    <= gbn_pkg::PH_AVOID;
                                            r_last_ack <= ack_seq;
                                        end
                                    end
                                endcase
                            end
                        end

                        gbn_pkg::CMD_SEND: begin
                            if (r_resend) begin
                                r_resend <= 1'b0;
                                r_back   <= 1'b1;
                            end
                            r_next <= send_from;
                            if (send_ok) begin
                                r_granted <= 1'b1;
                                r_sseq    <= send_from;
                                r_next    <= send_from + SEQ_BITS'(1);
                            end
                        end

                        default: begin
                            r_next     <= ack_seq;
                            r_base     <= ack_seq;
                            r_cwnd     <= gbn_pkg::ONE_PKT;
                            r_thresh   <= r_init_thresh;
                            r_last_ack <= '0;
                            r_dup      <= '0;
                            r_phase    <= gbn_pkg::PH_SLOW;
                            r_resend   <= 1'b0;
                            r_ticks    <= '0;
                        end
                    endcase
                end

                S_DIV: begin
                    // one restoring step per cycle
                    r_rem <= rem_ge ? rem_sub[15:0] : rem_sh[15:0];
                    r_quo <= quo_next;
                    if (r_div_cnt == '0) begin
                        // last quotient bit: fold the quotient into cwnd
                        r_cwnd  <= div_cw;
                        r_state <= S_RESP;
                    end else begin
                        r_div_cnt <= r_div_cnt - gbn_pkg::DIV_CNT_W'(1);
                    end
                end

                S_RESP: begin
                    if (out_free) begin
                        r_out_valid             <= 1'b1;
                        r_out.send_granted      <= r_granted;
                        r_out.send_seq          <= sseq_ext[7:0];
                        r_out.window_now        <= win;
                        r_out.went_back         <= r_back;
                        r_out.timed_out         <= r_tout;
                        r_out.phase             <= r_phase;
                        r_out.cwnd_whole        <= cw_whole;
                        r_out.threshold_now     <= r_thresh;
                        r_state                 <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
